// ===== rtl/god_pkg.sv =====
package god_pkg;

    localparam int LON_W = 29;
    localparam int LAT_W = 28;
    localparam int ROW_LEN_W = 11;
    localparam int CODE_W = 4;
    localparam int FLAG_W = 8;

    typedef logic [FLAG_W-1:0] t_flags;
    typedef logic [CODE_W-1:0] t_code;
    typedef logic signed [LON_W-1:0] t_lon;
    typedef logic signed [LAT_W-1:0] t_lat;
    typedef logic [ROW_LEN_W-1:0] t_row_len;

    localparam t_row_len ROW_LEN_RESET = 11'd1024;

    localparam int FB_XLON_ASC  = 0;
    localparam int FB_XLON_DESC = 1;
    localparam int FB_XLAT_ASC  = 2;
    localparam int FB_XLAT_DESC = 3;
    localparam int FB_YLON_ASC  = 4;
    localparam int FB_YLON_DESC = 5;
    localparam int FB_YLAT_ASC  = 6;
    localparam int FB_YLAT_DESC = 7;

    localparam t_code CODE_NONE       = 4'd0;
    localparam t_code CODE_IDENTITY   = 4'd1;
    localparam t_code CODE_ROT270     = 4'd2;
    localparam t_code CODE_ROT180     = 4'd3;
    localparam t_code CODE_ROT90       = 4'd4;
    localparam t_code CODE_M_IDENTITY = 4'd5;
    localparam t_code CODE_M_ROT270   = 4'd6;
    localparam t_code CODE_M_ROT180   = 4'd7;
    localparam t_code CODE_M_ROT90    = 4'd8;
    localparam t_code CODE_UNDET      = 4'd9;

    function automatic t_code classify(input t_flags f);
        logic xla, xld, xta, xtd, yla, yld, yta, ytd;
        t_code c;
        xla = f[FB_XLON_ASC];
        xld = f[FB_XLON_DESC];
        xta = f[FB_XLAT_ASC];
        xtd = f[FB_XLAT_DESC];
        yla = f[FB_YLON_ASC];
        yld = f[FB_YLON_DESC];
        yta = f[FB_YLAT_ASC];
        ytd = f[FB_YLAT_DESC];
        if ((xla && xld) || (yta && ytd)) begin
            c = CODE_NONE;
        end else if (xla && yta) begin
            c = CODE_IDENTITY;
        end else if (xta && yld) begin
            c = CODE_ROT270;
        end else if (xld && ytd) begin
            c = CODE_ROT180;
        end else if (xtd && yla) begin
            c = CODE_ROT90;
        end else if (xld && yta) begin
            c = CODE_M_IDENTITY;
        end else if (yld && xtd) begin
            c = CODE_M_ROT270;
        end else if (xla && ytd) begin
            c = CODE_M_ROT180;
        end else if (xta && yla) begin
            c = CODE_M_ROT90;
        end else begin
            c = CODE_UNDET;
        end
        return c;
    endfunction

endpackage

// ===== rtl/grid_orientation_detector_core.sv =====
// The last point of a grid leaves the compare stage and then sets the output register with the grid's result.
// Throughput: one point per cycle while o_in_stall is low; the line store is read as a point is taken in and
// written when it leaves the compare stage, with a bypass when both address one column.
// A pending result does not block points of the next grid until that grid's last point.
// Synchronous active-low reset sets the row length to 1024, clears the flags and
// the position; the line store contents are not cleared.
module grid_orientation_detector_core #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  god_pkg::t_row_len     i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  god_pkg::t_lon         i_lon_fixed,
    input  god_pkg::t_lat         i_lat_fixed,
    input  logic                  i_last_point,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output god_pkg::t_code        o_orientation_code
);

    import god_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int DW = LON_W + LAT_W;

    t_row_len r_row_length;

    logic          r_s1_valid;
    logic          r_s1_last;
    logic          r_s1_xcmp;
    logic          r_s1_ycmp;
    logic [CW-1:0] r_s1_col;
    t_lon          r_s1_lon;
    t_lat          r_s1_lat;
    t_lon          r_left_lon;
    t_lat          r_left_lat;
    logic          r_fwd;
    t_lon          r_fwd_lon;
    t_lat          r_fwd_lat;
    t_flags        r_flags;
    logic          r_out_valid;
    t_code         r_code;

    logic          in_acc;
    logic          s1_go;
    logic          s1_done;
    logic [CW-1:0] pos_col;
    logic          pos_first_row;
    logic [DW-1:0] ram_rdata;
    t_lon          above_lon;
    t_lat          above_lat;
    t_flags        new_flags;
    t_flags        acc_flags;

    assign s1_go      = !(r_s1_last && r_out_valid && i_out_stall);
    assign s1_done    = r_s1_valid && s1_go;
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_acc     = i_in_valid && !o_in_stall;

    god_position #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_position (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (in_acc),
        .i_last      (i_last_point),
        .i_row_length(r_row_length),
        .o_col       (pos_col),
        .o_first_row (pos_first_row)
    );

    god_line_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_COLUMNS)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (s1_done),
        .i_waddr(r_s1_col),
        .i_wdata({r_s1_lat, r_s1_lon}),
        .i_re   (in_acc),
        .i_raddr(pos_col),
        .o_rdata(ram_rdata)
    );

    assign above_lon = r_fwd ? r_fwd_lon : $signed(ram_rdata[LON_W-1:0]);
    assign above_lat = r_fwd ? r_fwd_lat : $signed(ram_rdata[DW-1:LON_W]);

    always_comb begin
        new_flags = '0;
        if (r_s1_xcmp) begin
            new_flags[FB_XLON_ASC]  = r_left_lon < r_s1_lon;
            new_flags[FB_XLON_DESC] = r_left_lon > r_s1_lon;
            new_flags[FB_XLAT_ASC]  = r_left_lat < r_s1_lat;
            new_flags[FB_XLAT_DESC] = r_left_lat > r_s1_lat;
        end
        if (r_s1_ycmp) begin
            new_flags[FB_YLON_ASC]  = above_lon < r_s1_lon;
            new_flags[FB_YLON_DESC] = above_lon > r_s1_lon;
            new_flags[FB_YLAT_ASC]  = above_lat < r_s1_lat;
            new_flags[FB_YLAT_DESC] = above_lat > r_s1_lat;
        end
    end

    assign acc_flags = r_flags | new_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LEN_RESET;
            r_s1_valid   <= 1'b0;
            r_flags      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_row_length <= i_cfg_data;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_done) begin
                r_flags <= r_s1_last ? '0 : acc_flags;
            end
            if (s1_done && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_last <= i_last_point;
            r_s1_xcmp <= pos_col != '0;
            r_s1_ycmp <= !pos_first_row;
            r_s1_col  <= pos_col;
            r_s1_lon  <= i_lon_fixed;
            r_s1_lat  <= i_lat_fixed;
            r_fwd     <= s1_done && (pos_col == r_s1_col);
            r_fwd_lon <= r_s1_lon;
            r_fwd_lat <= r_s1_lat;
        end
        if (s1_done) begin
            r_left_lon <= r_s1_lon;
            r_left_lat <= r_s1_lat;
        end
        if (s1_done && r_s1_last) begin
            r_code <= classify(acc_flags);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_orientation_code = r_code;

    a_stall_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s1_last && r_out_valid))
        else $error("input stalled without a blocked last point");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && r_s1_last) |=> (o_out_valid && r_flags == '0))
        else $error("last point did not produce a result or clear the flags");

    a_last_restarts_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_point) |=> (pos_col == '0 && pos_first_row))
        else $error("position not restarted after the last point");

    a_code_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_orientation_code <= CODE_UNDET))
        else $error("orientation code out of range");

endmodule

// ===== rtl/god_line_ram.sv =====
module god_line_ram #(
    parameter int WIDTH = 57,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/god_position.sv =====
module god_position #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic                           i_last,
    input  god_pkg::t_row_len              i_row_length,
    output logic [$clog2(MAX_COLUMNS)-1:0] o_col,
    output logic                           o_first_row
);

    import god_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int LW = (CW + 1 > ROW_LEN_W) ? CW + 1 : ROW_LEN_W;

    logic [CW-1:0] r_col, n_col;
    logic          r_first_row, n_first_row;
    logic [LW-1:0] len_raw;
    logic [LW-1:0] len_eff;
    logic [LW-1:0] col_inc;

    assign len_raw = LW'(i_row_length);
    assign col_inc = LW'(r_col) + LW'(1);

    always_comb begin
        if (len_raw == '0) begin
            len_eff = LW'(1);
        end else if (len_raw > LW'(MAX_COLUMNS)) begin
            len_eff = LW'(MAX_COLUMNS);
        end else begin
            len_eff = len_raw;
        end
    end

    always_comb begin
        n_col       = r_col;
        n_first_row = r_first_row;
        if (i_advance) begin
            if (i_last) begin
                n_col       = '0;
                n_first_row = 1'b1;
            end else if (col_inc >= len_eff) begin
                n_col       = '0;
                n_first_row = 1'b0;
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else begin
            r_col       <= n_col;
            r_first_row <= n_first_row;
        end
    end

    assign o_col       = r_col;
    assign o_first_row = r_first_row;

endmodule
